>>> sv/tfn_pkg.sv
// Shared widths, types and a helper function for the triangle face normal core.
package tfn_pkg;

	// Field widths of the transaction payloads.
	localparam int COORD_WIDTH      = 16;
	localparam int NORMAL_FRAC_BITS = 14;
	localparam int OUT_WIDTH        = 16;

	// Internal datapath widths, derived from the field widths above and from MANT_BITS.
	localparam int MANT_BITS      = 30;
	localparam int PRE_SHIFT      = (COORD_WIDTH > MANT_BITS) ? COORD_WIDTH - MANT_BITS : 0;
	localparam int EDGE_WIDTH     = COORD_WIDTH + 1 - PRE_SHIFT;
	localparam int PROD_WIDTH     = 2 * EDGE_WIDTH;
	localparam int CROSS_WIDTH    = PROD_WIDTH + 1;
	localparam int MAG_WIDTH      = PROD_WIDTH;
	localparam int MAX_SHIFT      = (MAG_WIDTH > MANT_BITS) ? MAG_WIDTH - MANT_BITS : 0;
	localparam int SHIFT_WIDTH    = (MAX_SHIFT > 0) ? $clog2(MAX_SHIFT + 1) : 1;
	localparam int SUM_WIDTH      = 2 * MANT_BITS + 2;
	localparam int ROOT_WIDTH     = MANT_BITS + 1;
	localparam int ISQRT_STEPS    = SUM_WIDTH / 2;
	localparam int QUOT_WIDTH     = NORMAL_FRAC_BITS + 1;
	localparam int DIVIDEND_WIDTH = MANT_BITS + NORMAL_FRAC_BITS + 1;
	localparam int REM_WIDTH      = ROOT_WIDTH + 1;

	// Pipeline depth of each unit and of the whole core.
	localparam int CROSS_STAGES = 3;
	localparam int PREP_STAGES  = 5;
	localparam int DIV_STAGES   = QUOT_WIDTH + 2;
	localparam int LATENCY      = CROSS_STAGES + PREP_STAGES + ISQRT_STEPS + DIV_STAGES;

	typedef logic signed [COORD_WIDTH-1:0] tfn_coord_t;
	typedef logic signed [OUT_WIDTH-1:0]   tfn_comp_t;

	// Input transaction: three triangle corners.
	typedef struct packed {
		tfn_coord_t first_x;
		tfn_coord_t first_y;
		tfn_coord_t first_z;
		tfn_coord_t second_x;
		tfn_coord_t second_y;
		tfn_coord_t second_z;
		tfn_coord_t third_x;
		tfn_coord_t third_y;
		tfn_coord_t third_z;
	} tfn_in_t;

	// Result transaction: unit normal and degenerate flag.
	typedef struct packed {
		tfn_comp_t normal_x;
		tfn_comp_t normal_y;
		tfn_comp_t normal_z;
		logic      degenerate;
	} tfn_out_t;

	// Control that travels with each item down the normalize pipeline.
	typedef struct packed {
		logic       valid;
		logic       degenerate;
		logic [2:0] neg;
	} tfn_ctl_t;

	typedef logic [2:0][MANT_BITS-1:0] tfn_mags_t;

	// Edge b - a, with the magnitude shifted down for very wide coordinates.
	function automatic logic signed [EDGE_WIDTH-1:0] edge_of(tfn_coord_t a, tfn_coord_t b);
		logic signed [COORD_WIDTH:0] diff;
		logic [COORD_WIDTH:0]        mag;
		logic [COORD_WIDTH:0]        res;
		diff = {b[COORD_WIDTH-1], b} - {a[COORD_WIDTH-1], a};
		mag  = diff[COORD_WIDTH] ? (COORD_WIDTH+1)'(-diff) : diff;
		mag  = mag >> PRE_SHIFT;
		res  = diff[COORD_WIDTH] ? (COORD_WIDTH+1)'(-mag) : mag;
		return res[EDGE_WIDTH-1:0];
	endfunction

endpackage

>>> sv/triangle_face_normal_core.sv
// Transactions pass through the cross, scale, root and divide units in that order.
// Throughput: one transaction per cycle; busy stays low, start may be high every cycle.
// The square root (one bit per stage) and the divider (one quotient bit per stage)
// set the depth. Each result shows on done for one cycle; the receiver cannot stall.
// Reset clears every valid bit in the pipeline; payload registers are not reset.
// Top level of the triangle face normal core.
module triangle_face_normal_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  tfn_pkg::tfn_in_t  corners,
	output logic              done,
	output tfn_pkg::tfn_out_t result
);
	import tfn_pkg::*;

	logic                          cross_valid;
	logic signed [CROSS_WIDTH-1:0] cross_prod [3];
	tfn_ctl_t                      prep_ctl, root_ctl;
	tfn_mags_t                     prep_mags, root_mags;
	logic [SUM_WIDTH-1:0]          sum;
	logic [ROOT_WIDTH-1:0]         len;

	// The pipeline advances every cycle, so a transaction is always taken.
	assign busy = 1'b0;

	tfn_cross u_cross (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (start && !busy),
		.corners    (corners),
		.out_valid  (cross_valid),
		.cross_prod (cross_prod)
	);

	tfn_prep u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (cross_valid),
		.cross_prod (cross_prod),
		.out_ctl    (prep_ctl),
		.mags       (prep_mags),
		.sum        (sum)
	);

	tfn_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ctl   (prep_ctl),
		.in_mags  (prep_mags),
		.radicand (sum),
		.out_ctl  (root_ctl),
		.out_mags (root_mags),
		.root     (len)
	);

	tfn_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ctl    (root_ctl),
		.in_mags   (root_mags),
		.len       (len),
		.out_valid (done),
		.result    (result)
	);

endmodule

>>> sv/tfn_cross.sv
// Edge vectors and cross product, three pipeline stages.
module tfn_cross (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  tfn_pkg::tfn_in_t                       corners,
	output logic                                   out_valid,
	output logic signed [tfn_pkg::CROSS_WIDTH-1:0] cross_prod [3]
);
	import tfn_pkg::*;

	logic                          valid_s1, valid_s2, valid_s3;
	logic signed [EDGE_WIDTH-1:0]  e1_s1 [3];
	logic signed [EDGE_WIDTH-1:0]  e2_s1 [3];
	logic signed [PROD_WIDTH-1:0]  prod_s2 [6];
	logic signed [CROSS_WIDTH-1:0] cross_s3 [3];

	// Valid bits follow the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Stage 1 forms both edges from the first corner.
	always_ff @(posedge clk) begin
		e1_s1[0] <= edge_of(corners.first_x, corners.second_x);
		e1_s1[1] <= edge_of(corners.first_y, corners.second_y);
		e1_s1[2] <= edge_of(corners.first_z, corners.second_z);
		e2_s1[0] <= edge_of(corners.first_x, corners.third_x);
		e2_s1[1] <= edge_of(corners.first_y, corners.third_y);
		e2_s1[2] <= edge_of(corners.first_z, corners.third_z);
	end

	// Stage 2 holds the six partial products.
	always_ff @(posedge clk) begin
		prod_s2[0] <= e1_s1[1] * e2_s1[2];
		prod_s2[1] <= e1_s1[2] * e2_s1[1];
		prod_s2[2] <= e1_s1[2] * e2_s1[0];
		prod_s2[3] <= e1_s1[0] * e2_s1[2];
		prod_s2[4] <= e1_s1[0] * e2_s1[1];
		prod_s2[5] <= e1_s1[1] * e2_s1[0];
	end

	// Stage 3 takes the differences.
	always_ff @(posedge clk) begin
		cross_s3[0] <= CROSS_WIDTH'(prod_s2[0]) - CROSS_WIDTH'(prod_s2[1]);
		cross_s3[1] <= CROSS_WIDTH'(prod_s2[2]) - CROSS_WIDTH'(prod_s2[3]);
		cross_s3[2] <= CROSS_WIDTH'(prod_s2[4]) - CROSS_WIDTH'(prod_s2[5]);
	end

	assign out_valid  = valid_s3;
	assign cross_prod = cross_s3;

endmodule

>>> sv/tfn_prep.sv
// Magnitudes, block scaling and sum of squares, five pipeline stages.
module tfn_prep (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	input  logic signed [tfn_pkg::CROSS_WIDTH-1:0] cross_prod [3],
	output tfn_pkg::tfn_ctl_t                      out_ctl,
	output tfn_pkg::tfn_mags_t                     mags,
	output logic [tfn_pkg::SUM_WIDTH-1:0]          sum
);
	import tfn_pkg::*;

	tfn_ctl_t                   ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic [MAG_WIDTH-1:0]       mag_s1 [3];
	logic [MAG_WIDTH-1:0]       mag_s2 [3];
	logic [SHIFT_WIDTH-1:0]     shift_s2;
	tfn_mags_t                  mg_s3, mg_s4, mg_s5;
	logic [2*MANT_BITS-1:0]     sq_s4 [3];
	logic [SUM_WIDTH-1:0]       sum_s5;
	tfn_ctl_t                   ctl_in;
	logic [MAG_WIDTH-1:0]       big;
	logic [SHIFT_WIDTH-1:0]     shift_c;

	// Sign and zero detection on the cross product.
	always_comb begin
		ctl_in.valid      = in_valid;
		ctl_in.degenerate = (cross_prod[0] == '0) && (cross_prod[1] == '0)
			&& (cross_prod[2] == '0);
		for (int i = 0; i < 3; i++) begin
			ctl_in.neg[i] = cross_prod[i][CROSS_WIDTH-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// Stage 1 takes the component magnitudes.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			mag_s1[i] <= cross_prod[i][CROSS_WIDTH-1] ? MAG_WIDTH'(-cross_prod[i])
				: MAG_WIDTH'(cross_prod[i]);
		end
	end

	// Smallest common shift that brings the largest magnitude below the mantissa range.
	always_comb begin
		big = mag_s1[0];
		if (mag_s1[1] > big) begin
			big = mag_s1[1];
		end
		if (mag_s1[2] > big) begin
			big = mag_s1[2];
		end
		shift_c = SHIFT_WIDTH'(MAX_SHIFT);
		for (int j = MAX_SHIFT; j >= 0; j--) begin
			if ((big >> j) < (MAG_WIDTH+1)'(1) << MANT_BITS) begin
				shift_c = SHIFT_WIDTH'(j);
			end
		end
	end

	// Stage 2 registers the shift, stage 3 applies it.
	always_ff @(posedge clk) begin
		mag_s2   <= mag_s1;
		shift_s2 <= shift_c;
		for (int i = 0; i < 3; i++) begin
			mg_s3[i] <= MANT_BITS'(mag_s2[i] >> shift_s2);
		end
	end

	// Stage 4 squares, stage 5 sums.
	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s4[i] <= mg_s3[i] * mg_s3[i];
		end
		mg_s4  <= mg_s3;
		sum_s5 <= SUM_WIDTH'(sq_s4[0]) + SUM_WIDTH'(sq_s4[1]) + SUM_WIDTH'(sq_s4[2]);
		mg_s5  <= mg_s4;
	end

	assign out_ctl = ctl_s5;
	assign mags    = mg_s5;
	assign sum     = sum_s5;

endmodule

>>> sv/tfn_isqrt.sv
// Pipelined integer square root, one result bit per stage.
module tfn_isqrt (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tfn_pkg::tfn_ctl_t               in_ctl,
	input  tfn_pkg::tfn_mags_t              in_mags,
	input  logic [tfn_pkg::SUM_WIDTH-1:0]   radicand,
	output tfn_pkg::tfn_ctl_t               out_ctl,
	output tfn_pkg::tfn_mags_t              out_mags,
	output logic [tfn_pkg::ROOT_WIDTH-1:0]  root
);
	import tfn_pkg::*;

	tfn_ctl_t             ctl_sk  [ISQRT_STEPS+1];
	tfn_mags_t            mags_sk [ISQRT_STEPS+1];
	logic [SUM_WIDTH-1:0] rad_sk  [ISQRT_STEPS+1];
	logic [SUM_WIDTH-1:0] root_sk [ISQRT_STEPS+1];

	assign ctl_sk[0]  = in_ctl;
	assign mags_sk[0] = in_mags;
	assign rad_sk[0]  = radicand;
	assign root_sk[0] = '0;

	for (genvar k = 0; k < ISQRT_STEPS; k++) begin : g_step
		localparam int BIT_POS = 2 * (ISQRT_STEPS - 1 - k);
		logic [SUM_WIDTH-1:0] trial;
		logic                 fits;

		// Try the next root bit against the remaining radicand.
		assign trial = root_sk[k] + (SUM_WIDTH'(1) << BIT_POS);
		assign fits  = rad_sk[k] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_sk[k+1] <= '0;
			end else begin
				ctl_sk[k+1] <= ctl_sk[k];
			end
		end

		always_ff @(posedge clk) begin
			mags_sk[k+1] <= mags_sk[k];
			if (fits) begin
				rad_sk[k+1]  <= rad_sk[k] - trial;
				root_sk[k+1] <= (root_sk[k] >> 1) + (SUM_WIDTH'(1) << BIT_POS);
			end else begin
				rad_sk[k+1]  <= rad_sk[k];
				root_sk[k+1] <= root_sk[k] >> 1;
			end
		end
	end

	assign out_ctl  = ctl_sk[ISQRT_STEPS];
	assign out_mags = mags_sk[ISQRT_STEPS];
	assign root     = root_sk[ISQRT_STEPS][ROOT_WIDTH-1:0];

endmodule

>>> sv/tfn_div.sv
// Pipelined restoring divider for the three components, plus sign and clamp.
module tfn_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  tfn_pkg::tfn_ctl_t              in_ctl,
	input  tfn_pkg::tfn_mags_t             in_mags,
	input  logic [tfn_pkg::ROOT_WIDTH-1:0] len,
	output logic                           out_valid,
	output tfn_pkg::tfn_out_t              result
);
	import tfn_pkg::*;

	localparam int SQ_WIDTH = (QUOT_WIDTH + 1 > OUT_WIDTH) ? QUOT_WIDTH + 1 : OUT_WIDTH;

	tfn_ctl_t              ctl_sk [QUOT_WIDTH+1];
	logic [ROOT_WIDTH-1:0] len_sk [QUOT_WIDTH+1];
	logic [REM_WIDTH-1:0]  rem_sk [QUOT_WIDTH+1][3];
	logic [QUOT_WIDTH-1:0] low_sk [QUOT_WIDTH+1][3];
	logic [QUOT_WIDTH-1:0] quo_sk [QUOT_WIDTH+1][3];
	logic                  valid_q;
	tfn_out_t              result_q;
	logic [ROOT_WIDTH-1:0] len_fix;
	logic [DIVIDEND_WIDTH-1:0] num [3];
	tfn_comp_t             comp [3];

	// Dividend with half the divisor added for rounding.
	always_comb begin
		len_fix = (len == '0) ? ROOT_WIDTH'(1) : len;
		for (int i = 0; i < 3; i++) begin
			num[i] = (DIVIDEND_WIDTH'(in_mags[i]) << NORMAL_FRAC_BITS)
				+ DIVIDEND_WIDTH'(len_fix >> 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sk[0] <= '0;
		end else begin
			ctl_sk[0] <= in_ctl;
		end
	end

	// Setup stage: the high dividend bits already lie below the divisor.
	always_ff @(posedge clk) begin
		len_sk[0] <= len_fix;
		for (int i = 0; i < 3; i++) begin
			rem_sk[0][i] <= REM_WIDTH'(num[i] >> QUOT_WIDTH);
			low_sk[0][i] <= num[i][QUOT_WIDTH-1:0];
			quo_sk[0][i] <= '0;
		end
	end

	for (genvar k = 0; k < QUOT_WIDTH; k++) begin : g_step
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_sk[k+1] <= '0;
			end else begin
				ctl_sk[k+1] <= ctl_sk[k];
			end
		end

		for (genvar i = 0; i < 3; i++) begin : g_lane
			logic [REM_WIDTH-1:0] part;
			logic                 fits;

			// Bring down one dividend bit and subtract the divisor if it fits.
			assign part = {rem_sk[k][i][REM_WIDTH-2:0], low_sk[k][i][QUOT_WIDTH-1-k]};
			assign fits = part >= {1'b0, len_sk[k]};

			always_ff @(posedge clk) begin
				rem_sk[k+1][i] <= fits ? part - {1'b0, len_sk[k]} : part;
				low_sk[k+1][i] <= low_sk[k][i];
				quo_sk[k+1][i] <= {quo_sk[k][i][QUOT_WIDTH-2:0], fits};
			end
		end

		always_ff @(posedge clk) begin
			len_sk[k+1] <= len_sk[k];
		end
	end

	// Clamp to one, apply the sign, zero a degenerate result and keep the low output bits.
	always_comb begin
		logic [QUOT_WIDTH-1:0] qc;
		logic [SQ_WIDTH-1:0]   sq;
		for (int i = 0; i < 3; i++) begin
			qc = quo_sk[QUOT_WIDTH][i];
			if (qc > (QUOT_WIDTH'(1) << NORMAL_FRAC_BITS)) begin
				qc = QUOT_WIDTH'(1) << NORMAL_FRAC_BITS;
			end
			sq = ctl_sk[QUOT_WIDTH].neg[i] ? SQ_WIDTH'(0) - SQ_WIDTH'(qc) : SQ_WIDTH'(qc);
			comp[i] = ctl_sk[QUOT_WIDTH].degenerate ? '0 : sq[OUT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= ctl_sk[QUOT_WIDTH].valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.normal_x   <= comp[0];
		result_q.normal_y   <= comp[1];
		result_q.normal_z   <= comp[2];
		result_q.degenerate <= ctl_sk[QUOT_WIDTH].degenerate;
	end

	assign out_valid = valid_q;
	assign result    = result_q;

endmodule

>>> sv/tfn_checker.sv
// Port-level checks for the triangle face normal core, bound to the top level.
module tfn_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input tfn_pkg::tfn_in_t  corners,
	input logic              done,
	input tfn_pkg::tfn_out_t result
);
	import tfn_pkg::*;

	localparam int WARM_WIDTH = $clog2(LATENCY + 1);

	logic [WARM_WIDTH-1:0] warm_q;
	logic                  warm;
	logic                  corners_equal;

	// Counts cycles since reset so latency checks only look at history after reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != WARM_WIDTH'(LATENCY)) begin
			warm_q <= warm_q + WARM_WIDTH'(1);
		end
	end

	assign warm = (warm_q == WARM_WIDTH'(LATENCY));
	assign corners_equal = (corners.first_x == corners.second_x)
		&& (corners.first_y == corners.second_y) && (corners.first_z == corners.second_z);

	// The core never refuses a transaction.
	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	// Every accepted transaction yields exactly one result after the fixed latency.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, LATENCY)))
		else $error("result count or latency mismatch");

	// Coincident first and second corners give a degenerate result.
	a_coincident: assert property (@(posedge clk) disable iff (!arst_n)
		warm && $past(start && !busy && corners_equal, LATENCY) |-> result.degenerate)
		else $error("coincident corners not flagged degenerate");

	// A degenerate result carries a zero normal.
	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.degenerate |->
			(result.normal_x == '0) && (result.normal_y == '0) && (result.normal_z == '0))
		else $error("degenerate result with nonzero normal");

	// Every component stays within plus or minus one.
	a_unit_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |->
			(result.normal_x <= 16'sd16384) && (result.normal_x >= -16'sd16384)
			&& (result.normal_y <= 16'sd16384) && (result.normal_y >= -16'sd16384)
			&& (result.normal_z <= 16'sd16384) && (result.normal_z >= -16'sd16384))
		else $error("normal component out of range");

endmodule

bind triangle_face_normal_core tfn_checker u_tfn_checker (.*);
